>>> rtl/core/gcc_pkg.sv
// shared types, constants and helpers for the grid component counter
`timescale 1ns / 1ps

package gcc_pkg;

    // store geometry
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CELL_W   = COL_W + ROW_W;
    localparam int CELLS    = 2 ** CELL_W;
    localparam int COLN_W   = COL_W + 1;
    localparam int ROWN_W   = ROW_W + 1;
    localparam int QPTR_W   = CELL_W + 1;

    // field and register widths
    localparam int CFG_W     = 7;
    localparam int FIELD_W   = 6;
    localparam int COUNT_W   = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]   DIM_RESET = 7'd64;

    typedef enum logic {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_MARK  = 1'b0,
        CMD_COUNT = 1'b1
    } t_op;

    // neighbor order: down, up, right, left
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    // per-cell store: {seen, mark}
    localparam logic [1:0] CELL_EMPTY   = 2'b00;
    localparam logic [1:0] CELL_MARKED  = 2'b01;
    localparam logic [1:0] CELL_VISITED = 2'b11;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_Q_RD,
        ST_NB_LOAD,
        ST_NB_RD,
        ST_NB_CHK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic mark_wr;
        logic scan_start;
        logic scan_rd;
        logic seed;
        logic scan_next;
        logic q_rd;
        logic nb_load;
        logic nb_rd;
        logic nb_push;
        logic nb_next;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic dims_empty;
        logic scan_last;
        logic cell_hit;
        logic q_empty;
        logic nb_valid;
        logic nb_last;
        logic res_busy;
    } t_status;

    function automatic logic [COLN_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        if (int'(v) > MAX_COLS) return COLN_W'(MAX_COLS);
        return COLN_W'(v);
    endfunction

    function automatic logic [ROWN_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        if (int'(v) > MAX_ROWS) return ROWN_W'(MAX_ROWS);
        return ROWN_W'(v);
    endfunction

endpackage

>>> rtl/core/gcc_in_if.sv
// command channel: mark or count request
`timescale 1ns / 1ps

interface gcc_in_if;
    import gcc_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FIELD_W-1:0] cell_col;
    logic [FIELD_W-1:0] cell_row;

    modport source (output valid, cmd, cell_col, cell_row, input ready);
    modport sink   (input valid, cmd, cell_col, cell_row, output ready);
endinterface

>>> rtl/core/gcc_out_if.sv
// result channel: group count
`timescale 1ns / 1ps

interface gcc_out_if;
    import gcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] group_count;

    modport source (output valid, group_count, input ready);
    modport sink   (input valid, group_count, output ready);
endinterface

>>> rtl/core/gcc_ctrl.sv
// sequencer for clear sweep, grid scan and breadth-first fill
`timescale 1ns / 1ps

module gcc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    output logic             o_in_ready,
    input  gcc_pkg::t_status i_status,
    output gcc_pkg::t_cmd    o_cmd
);
    import gcc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_xfer && i_in_cmd == CMD_COUNT) begin
                    n_state = i_status.dims_empty ? ST_FINISH : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                priority if (i_status.cell_hit) n_state = ST_Q_RD;
                else if (i_status.scan_last)    n_state = ST_FINISH;
                else                            n_state = ST_SCAN_RD;
            end
            ST_Q_RD: begin
                priority if (!i_status.q_empty) n_state = ST_NB_LOAD;
                else if (i_status.scan_last)    n_state = ST_FINISH;
                else                            n_state = ST_SCAN_RD;
            end
            ST_NB_LOAD: n_state = ST_NB_RD;
            ST_NB_RD: begin
                priority if (i_status.nb_valid) n_state = ST_NB_CHK;
                else if (i_status.nb_last)      n_state = ST_Q_RD;
                else                            n_state = ST_NB_RD;
            end
            ST_NB_CHK: n_state = i_status.nb_last ? ST_Q_RD : ST_NB_RD;
            ST_FINISH: begin
                if (!i_status.res_busy) n_state = ST_CLEAR;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    o_cmd.mark_wr    = (i_in_cmd == CMD_MARK);
                    o_cmd.scan_start = (i_in_cmd == CMD_COUNT);
                end
            end
            ST_SCAN_RD: o_cmd.scan_rd = 1'b1;
            ST_SCAN_CHK: begin
                o_cmd.seed      = i_status.cell_hit;
                o_cmd.scan_next = !i_status.cell_hit && !i_status.scan_last;
            end
            ST_Q_RD: begin
                o_cmd.q_rd      = !i_status.q_empty;
                o_cmd.scan_next = i_status.q_empty && !i_status.scan_last;
            end
            ST_NB_LOAD: o_cmd.nb_load = 1'b1;
            ST_NB_RD: begin
                o_cmd.nb_rd   = i_status.nb_valid;
                o_cmd.nb_next = !i_status.nb_valid && !i_status.nb_last;
            end
            ST_NB_CHK: begin
                o_cmd.nb_push = 1'b1;
                o_cmd.nb_next = !i_status.nb_last;
            end
            ST_FINISH: o_cmd.res_load = !i_status.res_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> rtl/core/gcc_datapath.sv
// cell store, search queue, scan and neighbor counters, result register
`timescale 1ns / 1ps

module gcc_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [gcc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [gcc_pkg::FIELD_W-1:0] i_cell_col,
    input  logic [gcc_pkg::FIELD_W-1:0] i_cell_row,
    input  gcc_pkg::t_cmd               i_cmd,
    output gcc_pkg::t_status            o_status,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [gcc_pkg::COUNT_W-1:0] o_group_count
);
    import gcc_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic [COLN_W-1:0] cols;
    logic [ROWN_W-1:0] rows;

    // stores
    logic [1:0]        r_cell_mem  [CELLS];
    logic [CELL_W-1:0] r_queue_mem [CELLS];
    logic [1:0]        r_cell_rd;
    logic [CELL_W-1:0] r_q_rd;

    // counters
    logic [CELL_W-1:0]  r_clr_addr;
    logic [COL_W-1:0]   r_scan_col;
    logic [ROW_W-1:0]   r_scan_row;
    logic [QPTR_W-1:0]  r_head;
    logic [QPTR_W-1:0]  r_tail;
    logic [CELL_W-1:0]  r_cur;
    t_dir               r_dir;
    logic [CELL_W-1:0]  r_nb_idx;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_res;
    logic               r_res_valid;

    logic [COLN_W-1:0] scan_col_inc;
    logic [ROWN_W-1:0] scan_row_inc;
    logic              scan_row_end;
    logic [CELL_W-1:0] scan_idx;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [COLN_W-1:0] cur_col_inc;
    logic [ROWN_W-1:0] cur_row_inc;
    logic [CELL_W-1:0] nb_idx;
    logic              nb_valid;
    logic              mark_in_range;
    logic [CELL_W-1:0] mark_idx;
    logic              cell_hit;
    logic              push;

    logic              cell_we;
    logic [CELL_W-1:0] cell_wa;
    logic [1:0]        cell_wd;
    logic              cell_re;
    logic [CELL_W-1:0] cell_ra;

    assign cols = clamp_cols(r_grid_width);
    assign rows = clamp_rows(r_grid_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_RESET;
            r_grid_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan position
    assign scan_col_inc = COLN_W'(r_scan_col) + COLN_W'(1);
    assign scan_row_inc = ROWN_W'(r_scan_row) + ROWN_W'(1);
    assign scan_row_end = (scan_col_inc == cols);
    assign scan_idx     = {r_scan_row, r_scan_col};

    // current queue cell and its neighbor
    assign cur_col     = r_cur[COL_W-1:0];
    assign cur_row     = r_cur[CELL_W-1:COL_W];
    assign cur_col_inc = COLN_W'(cur_col) + COLN_W'(1);
    assign cur_row_inc = ROWN_W'(cur_row) + ROWN_W'(1);

    always_comb begin
        nb_idx   = r_cur;
        nb_valid = 1'b0;
        unique case (r_dir)
            DIR_DOWN: begin
                nb_valid = cur_row_inc < rows;
                nb_idx   = {cur_row_inc[ROW_W-1:0], cur_col};
            end
            DIR_UP: begin
                nb_valid = cur_row != '0;
                nb_idx   = {cur_row - ROW_W'(1), cur_col};
            end
            DIR_RIGHT: begin
                nb_valid = cur_col_inc < cols;
                nb_idx   = {cur_row, cur_col_inc[COL_W-1:0]};
            end
            DIR_LEFT: begin
                nb_valid = cur_col != '0;
                nb_idx   = {cur_row, cur_col - COL_W'(1)};
            end
            default: ;
        endcase
    end

    // marks outside the store are dropped
    assign mark_in_range = (int'(i_cell_col) < MAX_COLS) && (int'(i_cell_row) < MAX_ROWS);
    assign mark_idx      = {ROW_W'(i_cell_row), COL_W'(i_cell_col)};

    assign cell_hit = (r_cell_rd == CELL_MARKED);
    assign push     = i_cmd.nb_push && cell_hit;

    // cell store port selection
    always_comb begin
        cell_we = 1'b0;
        cell_wa = r_clr_addr;
        cell_wd = CELL_EMPTY;
        priority if (i_cmd.clr_step) begin
            cell_we = 1'b1;
        end else if (i_cmd.mark_wr) begin
            cell_we = mark_in_range;
            cell_wa = mark_idx;
            cell_wd = CELL_MARKED;
        end else if (i_cmd.seed) begin
            cell_we = 1'b1;
            cell_wa = scan_idx;
            cell_wd = CELL_VISITED;
        end else if (push) begin
            cell_we = 1'b1;
            cell_wa = r_nb_idx;
            cell_wd = CELL_VISITED;
        end
        cell_re = i_cmd.scan_rd || i_cmd.nb_rd;
        cell_ra = i_cmd.nb_rd ? nb_idx : scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) r_cell_mem[cell_wa] <= cell_wd;
        if (cell_re) r_cell_rd <= r_cell_mem[cell_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed)      r_queue_mem[CELL_W'(0)] <= scan_idx;
        else if (push)       r_queue_mem[r_tail[CELL_W-1:0]] <= r_nb_idx;
        if (i_cmd.q_rd)      r_q_rd <= r_queue_mem[r_head[CELL_W-1:0]];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + CELL_W'(1);
            if (i_cmd.res_load) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (i_cmd.seed) begin
                r_head <= '0;
                r_tail <= QPTR_W'(1);
            end else begin
                if (i_cmd.q_rd) r_head <= r_head + QPTR_W'(1);
                if (push)       r_tail <= r_tail + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_col <= '0;
            r_scan_row <= '0;
            r_count    <= '0;
        end else begin
            if (i_cmd.scan_next) begin
                if (scan_row_end) begin
                    r_scan_col <= '0;
                    r_scan_row <= scan_row_inc[ROW_W-1:0];
                end else begin
                    r_scan_col <= scan_col_inc[COL_W-1:0];
                end
            end
            if (i_cmd.seed && r_count != COUNT_MAX) r_count <= r_count + COUNT_W'(1);
        end
        if (i_cmd.nb_load) begin
            r_cur <= r_q_rd;
            r_dir <= DIR_DOWN;
        end else if (i_cmd.nb_next) begin
            r_dir <= t_dir'(r_dir + 2'd1);
        end
        if (i_cmd.nb_rd)    r_nb_idx <= nb_idx;
        if (i_cmd.res_load) r_res    <= r_count;
    end

    assign o_status.clr_last   = (r_clr_addr == '1);
    assign o_status.dims_empty = (cols == '0) || (rows == '0);
    assign o_status.scan_last  = scan_row_end && (scan_row_inc == rows);
    assign o_status.cell_hit   = cell_hit;
    assign o_status.q_empty    = (r_head == r_tail);
    assign o_status.nb_valid   = nb_valid;
    assign o_status.nb_last    = (r_dir == DIR_LEFT);
    assign o_status.res_busy   = r_res_valid;

    assign o_res_valid   = r_res_valid;
    assign o_group_count = r_res;

endmodule

>>> rtl/core/grid_component_counter.sv
// top level: 4-connected group counter over a configurable binary grid
`timescale 1ns / 1ps

// channel   dir  fields                     transfer when
// in_chan   in   cmd, cell_col, cell_row    valid & ready
// out_chan  out  group_count                valid & ready
// cfg       in   i_cfg_idx, i_cfg_data      i_cfg_we
//
// marks stream back to back while the block is idle
// a count of a non-empty grid scans it cell by cell (read, then check); a marked
// cell seeds a group that is filled breadth-first through the queue, each filled
// cell probing its four neighbors, all through one cell store with one write port
// and one read port; the finish state then loads the result once out_chan has
// taken the last one, and a clear sweep (one cell a cycle over all 4096 cells)
// empties the store; the same sweep runs after reset before in_chan is ready
// the result sits in an output register, so a stalled out_chan only holds off the next count's finish, not marks

module grid_component_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gcc_in_if.sink                      in_chan,
    gcc_out_if.source                   out_chan,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [gcc_pkg::CFG_W-1:0]   i_cfg_data
);
    import gcc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: owns the input handshake
    gcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_chan.valid),
        .i_in_cmd   (in_chan.cmd),
        .o_in_ready (in_chan.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // stores, counters and the result register
    gcc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cell_col    (in_chan.cell_col),
        .i_cell_row    (in_chan.cell_row),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_res_valid   (out_chan.valid),
        .i_res_ready   (out_chan.ready),
        .o_group_count (out_chan.group_count)
    );

endmodule
